>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define VTYP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define VTYP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/core/vtyp_pkg.sv
// types, constants and threshold tables for the yaw/pitch core
package vtyp_pkg;

    localparam int FRAC_BITS = 30;
    localparam int ROM_DEPTH = 128;

    localparam logic [6:0] MAX_DEG = 7'd89;
    localparam logic [6:0] DEG_45  = 7'd45;
    localparam logic [6:0] DEG_90  = 7'd90;
    localparam logic [8:0] DEG_180 = 9'd180;
    localparam logic [8:0] DEG_360 = 9'd360;
    localparam logic [8:0] ELEV_UP = 9'd90;
    localparam logic [8:0] ELEV_DN = 9'd270;

    localparam longint unsigned DEC_DEN  = 64'd1000000000000000;
    localparam longint unsigned COS1_DEC = 64'd999847695156391;
    localparam longint unsigned SIN1_DEC = 64'd17452406437284;

    typedef logic [30:0] t_rom [ROM_DEPTH];

    typedef struct packed {
        logic [31:0] p2;
        logic [31:0] q2;
        logic [6:0]  n;
    } t_lane;

    typedef struct packed {
        logic x_pos;
        logic x_zero;
        logic y_neg;
        logic z_pos;
        logic z_neg;
        logic hz;
        logic exact;
    } t_side;

    function automatic longint unsigned dec_to_fix(input longint unsigned num);
        longint unsigned rem;
        longint unsigned q;
        rem = num;
        q   = 0;
        for (int b = 0; b < FRAC_BITS; b++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= DEC_DEN) begin
                rem = rem - DEC_DEN;
                q   = q | 64'd1;
            end
        end
        if (2 * rem >= DEC_DEN) begin
            q = q + 1;
        end
        return q;
    endfunction

    function automatic longint unsigned fix_round(input longint unsigned v);
        return (v + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    endfunction

    // squared cos (want_sin = 0) or squared sin (want_sin = 1) per degree
    function automatic t_rom build_rom(input bit want_sin);
        t_rom r;
        longint unsigned c1;
        longint unsigned s1;
        longint unsigned cc;
        longint unsigned ss;
        longint unsigned a;
        longint unsigned b;
        longint unsigned nc;
        longint unsigned ns;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            r[k] = '0;
        end
        c1 = dec_to_fix(COS1_DEC);
        s1 = dec_to_fix(SIN1_DEC);
        cc = 64'd1 << FRAC_BITS;
        ss = 0;
        r[0] = want_sin ? 31'd0 : 31'(fix_round(cc * cc));
        for (int k = 1; k <= 89; k++) begin
            a  = cc * c1;
            b  = ss * s1;
            nc = (a >= b) ? fix_round(a - b) : 64'd0;
            ns = fix_round(ss * c1 + cc * s1);
            cc = nc;
            ss = ns;
            r[k] = want_sin ? 31'(fix_round(ss * ss)) : 31'(fix_round(cc * cc));
        end
        return r;
    endfunction

    localparam t_rom COS_SQ = build_rom(1'b0);
    localparam t_rom SIN_SQ = build_rom(1'b1);

endpackage

>>> rtl/core/vector_to_yaw_pitch_core.sv
// direction vector to whole-degree yaw and negated pitch, pipelined
//  channel   valid         ready         payload
//  in        i_in_valid    o_in_ready    i_x_component, i_y_component, i_z_component
//  out       o_out_valid   i_out_ready   o_neg_pitch_deg, o_yaw_deg
// one vector per cycle while the output is not stalled; stages: squares, sum, 7 search steps of 2, result
// the threshold multipliers of each search step set the stage depth
// synchronous reset clears all valid bits; the tables are constant
// a stall on the output freezes the whole pipeline and drops o_in_ready
module vector_to_yaw_pitch_core import vtyp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic signed [15:0] i_x_component,
    input  logic signed [15:0] i_y_component,
    input  logic signed [15:0] i_z_component,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic signed [9:0] o_neg_pitch_deg,
    output logic        [8:0] o_yaw_deg
);

    localparam int STEPS = 7;

    logic en;

    logic        r_v1;
    logic [30:0] r_x2;
    logic [30:0] r_y2;
    logic [30:0] r_z2;
    logic        r_x_pos;
    logic        r_y_neg;
    logic        r_z_pos;
    logic        r_z_neg;
    logic        r_hz;
    logic signed [31:0] x_sq;
    logic signed [31:0] y_sq;
    logic signed [31:0] z_sq;

    logic  r_v2;
    t_side r_side2;
    t_lane r_yaw2;
    t_lane r_pitch2;

    logic  v_c     [STEPS+1];
    t_side side_c  [STEPS+1];
    t_lane yaw_c   [STEPS+1];
    t_lane pitch_c [STEPS+1];

    logic              r_out_valid;
    logic signed [9:0] r_neg_pitch;
    logic        [8:0] r_yaw;
    logic signed [9:0] n_neg_pitch;
    logic        [8:0] n_yaw;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    assign x_sq = i_x_component * i_x_component;
    assign y_sq = i_y_component * i_y_component;
    assign z_sq = i_z_component * i_z_component;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= i_in_valid;
            r_v2        <= r_v1;
            r_out_valid <= v_c[STEPS];
        end
    end

    // squares and signs
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x2    <= x_sq[30:0];
            r_y2    <= y_sq[30:0];
            r_z2    <= z_sq[30:0];
            r_x_pos <= (i_x_component > 16'sd0);
            r_y_neg <= i_y_component[15];
            r_z_pos <= (i_z_component > 16'sd0);
            r_z_neg <= i_z_component[15];
            r_hz    <= (i_x_component == 16'sd0) && (i_y_component == 16'sd0);
        end
    end

    // horizontal length squared and exact-angle flags
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side2.x_pos  <= r_x_pos;
            r_side2.x_zero <= (r_x2 == 31'd0);
            r_side2.y_neg  <= r_y_neg;
            r_side2.z_pos  <= r_z_pos;
            r_side2.z_neg  <= r_z_neg;
            r_side2.hz     <= r_hz;
            r_side2.exact  <= (r_x2 == 31'd0) || (r_y2 == 31'd0) || (r_x2 == r_y2);
            r_yaw2.p2      <= {1'b0, r_y2};
            r_yaw2.q2      <= {1'b0, r_x2};
            r_yaw2.n       <= '0;
            r_pitch2.p2    <= {1'b0, r_z2};
            r_pitch2.q2    <= 32'(r_x2) + 32'(r_y2);
            r_pitch2.n     <= '0;
        end
    end

    assign v_c[0]     = r_v2;
    assign side_c[0]  = r_side2;
    assign yaw_c[0]   = r_yaw2;
    assign pitch_c[0] = r_pitch2;

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        vtyp_step #(
            .STEP_BIT(7'(1 << (STEPS - 1 - g)))
        ) u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(v_c[g]),
            .i_side (side_c[g]),
            .i_yaw  (yaw_c[g]),
            .i_pitch(pitch_c[g]),
            .o_valid(v_c[g+1]),
            .o_side (side_c[g+1]),
            .o_yaw  (yaw_c[g+1]),
            .o_pitch(pitch_c[g+1])
        );
    end

    // quadrant fold and wrap
    always_comb begin
        t_side      s;
        logic [8:0] a_y;
        logic [8:0] a_p;
        logic [8:0] up;
        logic [8:0] elev;
        s    = side_c[STEPS];
        a_y  = s.x_zero ? 9'(DEG_90) : 9'(yaw_c[STEPS].n);
        a_p  = 9'(pitch_c[STEPS].n);
        up   = s.exact ? 9'd0 : 9'd1;
        if (s.hz) begin
            n_yaw = '0;
            elev  = s.z_pos ? ELEV_UP : ELEV_DN;
        end else begin
            if (!s.y_neg) begin
                n_yaw = s.x_pos ? a_y : DEG_180 - a_y - up;
            end else if (s.x_pos) begin
                n_yaw = (a_y == 9'd0) ? 9'd0 : DEG_360 - a_y;
            end else begin
                n_yaw = DEG_180 + a_y + up;
            end
            if (!s.z_neg) begin
                elev = a_p;
            end else begin
                elev = (a_p == 9'd0) ? 9'd0 : DEG_360 - a_p;
            end
        end
        n_neg_pitch = 10'sd0 - $signed({1'b0, elev});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yaw       <= n_yaw;
            r_neg_pitch <= n_neg_pitch;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_yaw_deg       = r_yaw;
    assign o_neg_pitch_deg = r_neg_pitch;

endmodule

>>> rtl/core/vtyp_step.sv
// one binary search step over the degree thresholds, two register stages
module vtyp_step import vtyp_pkg::*; #(
    parameter logic [6:0] STEP_BIT = 7'd64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_side i_side,
    input  t_lane i_yaw,
    input  t_lane i_pitch,
    output logic  o_valid,
    output t_side o_side,
    output t_lane o_yaw,
    output t_lane o_pitch
);

    typedef struct packed {
        t_lane       lane;
        logic [6:0]  cand;
        logic        in_range;
        logic        is45;
        logic        ge;
        logic [62:0] prod_p;
        logic [62:0] prod_q;
    } t_prod;

    logic  r_valid_a;
    t_side r_side_a;
    t_prod r_yaw_a;
    t_prod r_pitch_a;
    t_prod n_yaw_a;
    t_prod n_pitch_a;

    logic  r_valid_b;
    t_side r_side_b;
    t_lane r_yaw_b;
    t_lane r_pitch_b;
    t_lane n_yaw_b;
    t_lane n_pitch_b;

    function automatic t_prod prod_of(input t_lane l);
        t_prod r;
        r.lane     = l;
        r.cand     = l.n + STEP_BIT;
        r.in_range = (r.cand <= MAX_DEG);
        r.is45     = (r.cand == DEG_45);
        r.ge       = (l.p2 >= l.q2);
        r.prod_p   = 63'(l.p2) * 63'(COS_SQ[r.cand]);
        r.prod_q   = 63'(l.q2) * 63'(SIN_SQ[r.cand]);
        return r;
    endfunction

    function automatic t_lane pick(input t_prod p);
        t_lane r;
        logic  hit;
        hit = p.is45 ? p.ge : (p.prod_p >= p.prod_q);
        r   = p.lane;
        if (p.in_range && hit) begin
            r.n = p.cand;
        end
        return r;
    endfunction

    always_comb begin
        n_yaw_a   = prod_of(i_yaw);
        n_pitch_a = prod_of(i_pitch);
        n_yaw_b   = pick(r_yaw_a);
        n_pitch_b = pick(r_pitch_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side_a  <= i_side;
            r_yaw_a   <= n_yaw_a;
            r_pitch_a <= n_pitch_a;
            r_side_b  <= r_side_a;
            r_yaw_b   <= n_yaw_b;
            r_pitch_b <= n_pitch_b;
        end
    end

    assign o_valid = r_valid_b;
    assign o_side  = r_side_b;
    assign o_yaw   = r_yaw_b;
    assign o_pitch = r_pitch_b;

endmodule

>>> rtl/core/vtyp_checker.sv
// port-level checks for the yaw/pitch core, bound to the top level
`include "assert_macros.svh"

module vtyp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic signed [15:0] i_x_component,
    input logic signed [15:0] i_y_component,
    input logic signed [15:0] i_z_component,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic signed [9:0] o_neg_pitch_deg,
    input logic        [8:0] o_yaw_deg
);

    `VTYP_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_yaw_deg) && $stable(o_neg_pitch_deg), "stalled transfer changed")
    `VTYP_ASSERT(a_yaw_range, o_out_valid |-> o_yaw_deg < 9'd360, "yaw out of range")
    `VTYP_ASSERT(a_pitch_range, o_out_valid |-> (o_neg_pitch_deg <= 10'sd0 && o_neg_pitch_deg >= -10'sd90) || (o_neg_pitch_deg <= -10'sd270 && o_neg_pitch_deg >= -10'sd359), "pitch out of range")
    `VTYP_ASSERT(a_ready_when_empty, !o_out_valid |-> o_in_ready, "ready low with empty output")
    `VTYP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind vector_to_yaw_pitch_core vtyp_checker u_vtyp_checker (.*);

>>> test/vector_to_yaw_pitch_core_test.sv
// self-checking testbench for the vector to yaw/pitch core
module vector_to_yaw_pitch_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 930;
    localparam int HOLD_AT = 300;
    localparam int HOLD_LEN = 150;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        bit                 typed;
        logic signed [9:0]  pitch;
        logic [8:0]         yaw;
    } t_vec_row;

    typedef struct {
        logic signed [9:0] pitch;
        logic [8:0]        yaw;
    } t_angles;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic signed [15:0] i_x_component = '0;
    logic signed [15:0] i_y_component = '0;
    logic signed [15:0] i_z_component = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic signed [9:0] o_neg_pitch_deg;
    logic        [8:0] o_yaw_deg;

    longint unsigned cos_sq_tab [90];
    longint unsigned sin_sq_tab [90];
    t_angles         angles_due [$];
    int              err_cnt = 0;
    int              sent_cnt = 0;

    vector_to_yaw_pitch_core DUT (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned q30_round(input longint unsigned v);
        return (v + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint unsigned to_q30(input longint unsigned num);
        longint unsigned den;
        longint unsigned rem;
        longint unsigned q;
        den = 64'd1000000000000000;
        rem = num;
        q = 0;
        for (int b = 0; b < 30; b++) begin
            rem = rem * 2;
            q = q * 2;
            if (rem >= den) begin
                rem = rem - den;
                q = q + 1;
            end
        end
        if (2 * rem >= den) begin
            q = q + 1;
        end
        return q;
    endfunction

    initial begin
        longint unsigned c1, s1, cc, ss, pa, pb, nc;
        c1 = to_q30(64'd999847695156391);
        s1 = to_q30(64'd17452406437284);
        cc = 64'd1 << 30;
        ss = 0;
        cos_sq_tab[0] = q30_round(cc * cc);
        sin_sq_tab[0] = 0;
        for (int k = 1; k < 90; k++) begin
            pa = cc * c1;
            pb = ss * s1;
            nc = (pa >= pb) ? q30_round(pa - pb) : 64'd0;
            ss = q30_round(ss * c1 + cc * s1);
            cc = nc;
            cos_sq_tab[k] = q30_round(cc * cc);
            sin_sq_tab[k] = q30_round(ss * ss);
        end
    end

    // whole degrees below atan(sqrt(num2/den2)), flags an exact angle
    function automatic int whole_deg(input longint unsigned num2, input longint unsigned den2,
                                     output bit exact);
        int n;
        bit hit;
        n = 0;
        exact = 1'b1;
        if (den2 == 0) return 90;
        if (num2 == 0) return 0;
        exact = (num2 == den2);
        for (int k = 1; k < 90; k++) begin
            if (k == 45) hit = (num2 >= den2);
            else hit = (num2 * cos_sq_tab[k] >= den2 * sin_sq_tab[k]);
            if (!hit) break;
            n = k;
        end
        return n;
    endfunction

    function automatic t_angles yaw_pitch_of(input logic signed [15:0] x,
                                             input logic signed [15:0] y,
                                             input logic signed [15:0] z);
        longint unsigned x2, y2, z2;
        int a, yaw, elev;
        bit ex;
        t_angles r;
        x2 = longint'(x) * longint'(x);
        y2 = longint'(y) * longint'(y);
        z2 = longint'(z) * longint'(z);
        if (x == 0 && y == 0) begin
            yaw = 0;
            elev = (z > 0) ? 90 : 270;
        end else begin
            a = whole_deg(y2, x2, ex);
            if (y >= 0) yaw = (x > 0) ? a : 180 - a - (ex ? 0 : 1);
            else if (x > 0) yaw = (a == 0) ? 0 : 360 - a;
            else yaw = 180 + a + (ex ? 0 : 1);
            a = whole_deg(z2, x2 + y2, ex);
            if (z >= 0) elev = a;
            else elev = (a == 0) ? 0 : 360 - a;
        end
        r.pitch = 10'(-elev);
        r.yaw = 9'(yaw);
        return r;
    endfunction

    // sender bursts: burst_left items then a random gap
    int burst_left = 0;

    task automatic offer(input t_vec_row row);
        t_angles due;
        bit acc;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_x_component <= row.x;
        i_y_component <= row.y;
        i_z_component <= row.z;
        do begin
            @(negedge i_clk);
            acc = o_in_ready;
            @(posedge i_clk);
        end while (!acc);
        if (row.typed) begin
            due.pitch = row.pitch;
            due.yaw = row.yaw;
        end else begin
            due = yaw_pitch_of(row.x, row.y, row.z);
        end
        angles_due.push_back(due);
        sent_cnt++;
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'($signed($urandom_range(0, 6)) - 3);
            2: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            3: return 16'($signed($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    t_vec_row vec_table [] = '{
        '{16'sd0, 16'sd0, 16'sd0, 1'b1, -10'sd270, 9'd0},
        '{16'sd0, 16'sd0, 16'sd1, 1'b1, -10'sd90, 9'd0},
        '{16'sd0, 16'sd0, 16'sh7fff, 1'b1, -10'sd90, 9'd0},
        '{16'sd0, 16'sd0, 16'sh8000, 1'b1, -10'sd270, 9'd0},
        '{16'sd1, 16'sd0, 16'sd0, 1'b1, 10'sd0, 9'd0},
        '{-16'sd1, 16'sd0, 16'sd0, 1'b1, 10'sd0, 9'd180},
        '{16'sd0, 16'sd1, 16'sd0, 1'b1, 10'sd0, 9'd90},
        '{16'sd0, -16'sd1, 16'sd0, 1'b1, 10'sd0, 9'd270},
        '{16'sd1, 16'sd1, 16'sd0, 1'b1, 10'sd0, 9'd45},
        '{-16'sd1, 16'sd1, 16'sd0, 1'b1, 10'sd0, 9'd135},
        '{-16'sd1, -16'sd1, 16'sd0, 1'b1, 10'sd0, 9'd225},
        '{16'sd1, -16'sd1, 16'sd0, 1'b1, 10'sd0, 9'd315},
        '{16'sd1, 16'sd0, 16'sd1, 1'b1, -10'sd45, 9'd0},
        '{16'sd1, 16'sd0, -16'sd1, 1'b1, -10'sd315, 9'd0},
        '{16'sh7fff, -16'sd1, 16'sd0, 1'b0, 10'sd0, 9'd0},
        '{16'sh7fff, 16'sd0, -16'sd1, 1'b0, 10'sd0, 9'd0},
        '{-16'sd2, -16'sd1, 16'sd3, 1'b0, 10'sd0, 9'd0},
        '{-16'sd2, 16'sd1, -16'sd3, 1'b0, 10'sd0, 9'd0},
        '{16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, 10'sd0, 9'd0},
        '{16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0, 10'sd0, 9'd0},
        '{16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 10'sd0, 9'd0},
        '{16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 10'sd0, 9'd0},
        '{16'sd1, 16'sh8000, 16'sd1, 1'b0, 10'sd0, 9'd0},
        '{16'sh8000, 16'sd1, 16'sh8000, 1'b0, 10'sd0, 9'd0}
    };

    initial begin
        t_vec_row row;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (vec_table[i]) offer(vec_table[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            row.x = rand_comp();
            row.y = rand_comp();
            row.z = rand_comp();
            row.typed = 1'b0;
            offer(row);
        end
        i_in_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stalls, ready stretches, one long hold-off
    initial begin
        int mode_left;
        bit busy;
        mode_left = 0;
        busy = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (sent_cnt >= HOLD_AT && sent_cnt < HOLD_AT + 5) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                busy = ($urandom_range(0, 2) != 0);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            i_out_ready <= busy ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    // result transfers are decided by values stable before the edge
    always @(negedge i_clk) begin
        t_angles due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (angles_due.size() == 0) begin
                $error("result with nothing expected: pitch %0d yaw %0d",
                       o_neg_pitch_deg, o_yaw_deg);
                err_cnt++;
            end else begin
                due = angles_due.pop_front();
                if (o_neg_pitch_deg !== due.pitch) begin
                    $error("neg_pitch_deg expected %0d got %0d", due.pitch, o_neg_pitch_deg);
                    err_cnt++;
                end
                if (o_yaw_deg !== due.yaw) begin
                    $error("yaw_deg expected %0d got %0d", due.yaw, o_yaw_deg);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #1ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/vtyp_pkg.sv
rtl/core/vtyp_step.sv
rtl/core/vector_to_yaw_pitch_core.sv
rtl/core/vtyp_checker.sv
test/vector_to_yaw_pitch_core_test.sv
